// ===== design/date_offset_by_days_macros.svh =====
// Assertion macros for the date offset block.
// Included by design/date_offset_by_days.sv; expects clk_i and rst_ni in scope.
`ifndef DATE_OFFSET_BY_DAYS_MACROS_SVH
`define DATE_OFFSET_BY_DAYS_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DOBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define DOBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dobd_pkg.sv =====
// Shared constants, state encoding and month length lookup for the date offset block.
// No dependencies.
`default_nettype none

package dobd_pkg;

  localparam int unsigned CountBitsDefault = 16;

  localparam logic [13:0] YearMin  = 14'd1;
  localparam logic [13:0] YearMax  = 14'd9999;
  localparam logic [3:0]  Months   = 4'd12;
  localparam logic [3:0]  MonthMin = 4'd1;
  localparam logic [4:0]  DayMin   = 5'd1;
  localparam logic [4:0]  DecDays  = 5'd31;
  localparam logic [13:0] Mod25    = 14'd25;
  localparam logic [13:0] Mod25Top = 14'd24;
  // 25 << 9 is the largest shifted multiple that fits in 14 bits, and it is above the top year
  localparam logic [3:0]  ModSteps = 4'd10;

  // Common row first, leap row second
  localparam logic [4:0] MonthLenTable [24] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOD   = 5'b00010,
    ST_CLAMP = 5'b00100,
    ST_STEP  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [4:0] idx;
    idx = leap ? (5'(month) + 5'd11) : (5'(month) - 5'd1);
    return MonthLenTable[idx];
  endfunction

endpackage

`default_nettype wire

// ===== design/date_offset_by_days.sv =====
// One transaction at a time: the ready goes low from accept until the result is
// loaded into the output register, so the month-stepping loop holds off new requests.
// A year mod 25 pass precedes the loop and feeds the leap-year tracking.
// Reset (async, active low) clears the sequencer and the output valid only.
`default_nettype none

module date_offset_by_days
  import dobd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic                  req_type_i,
  input  wire logic [13:0]           start_year_i,
  input  wire logic [3:0]            start_month_i,
  input  wire logic [4:0]            start_day_i,
  input  wire logic [COUNT_BITS-1:0] day_count_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [13:0]           result_year_o,
  output      logic [3:0]            result_month_o,
  output      logic [4:0]            result_day_o,
  output      logic                  year_overflow_o
);

  `include "date_offset_by_days_macros.svh"

  state_e state_q, state_d;

  logic                  dir_q, dir_d;
  logic [13:0]           y_q, y_d;
  logic [3:0]            m_q, m_d;
  logic [4:0]            d_q, d_d;
  logic [COUNT_BITS-1:0] n_q, n_d;
  logic                  ovf_q, ovf_d;
  logic [13:0]           r_q, r_d;   // year mod 25 once the mod pass ends
  logic [3:0]            k_q, k_d;

  logic                  out_valid_q;
  logic [13:0]           res_year_q;
  logic [3:0]            res_month_q;
  logic [4:0]            res_day_q;
  logic                  res_ovf_q;
  logic                  out_load;

  logic        leap;
  logic [4:0]  cur_len;
  logic [4:0]  rest;
  logic [13:0] div_term;
  logic [13:0] y_in;
  logic [3:0]  m_in;

  logic        in_accept;
  logic        step_date_ok;
  logic        res_clamped;

  // y%100 == 0 needs y%4 == 0 and y%25 == 0; then y%400 == 0 needs y%16 == 0
  assign leap     = (y_q[1:0] == 2'd0) && ((r_q != 14'd0) || (y_q[3:0] == 4'd0));
  assign cur_len  = month_len(leap, m_q);
  assign rest     = cur_len - d_q;
  assign div_term = Mod25 << k_q;

  always_comb begin
    y_in = start_year_i;
    if (start_year_i < YearMin) y_in = YearMin;
    if (start_year_i > YearMax) y_in = YearMax;
    m_in = start_month_i;
    if (start_month_i < MonthMin) m_in = MonthMin;
    if (start_month_i > Months)   m_in = Months;
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    dir_d   = dir_q;
    y_d     = y_q;
    m_d     = m_q;
    d_d     = d_q;
    n_d     = n_q;
    ovf_d   = ovf_q;
    r_d     = r_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dir_d   = req_type_i;
          y_d     = y_in;
          m_d     = m_in;
          d_d     = (start_day_i == 5'd0) ? DayMin : start_day_i;
          n_d     = day_count_i;
          ovf_d   = 1'b0;
          r_d     = y_in;
          k_d     = ModSteps - 4'd1;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        // restoring reduction, one multiple of 25 per cycle
        if (r_q >= div_term) r_d = r_q - div_term;
        k_d = k_q - 4'd1;
        if (k_q == 4'd0) state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (d_q > cur_len) d_d = cur_len;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (n_q == '0) begin
          state_d = ST_DONE;
        end else if (!dir_q) begin
          if (n_q > COUNT_BITS'(rest)) begin
            n_d = n_q - (COUNT_BITS'(rest) + COUNT_BITS'(1));
            d_d = DayMin;
            if (m_q == Months) begin
              if (y_q == YearMax) begin
                m_d     = Months;
                d_d     = DecDays;
                ovf_d   = 1'b1;
                state_d = ST_DONE;
              end else begin
                y_d = y_q + 14'd1;
                m_d = MonthMin;
                r_d = (r_q == Mod25Top) ? 14'd0 : (r_q + 14'd1);
              end
            end else begin
              m_d = m_q + 4'd1;
            end
          end else begin
            d_d = d_q + n_q[4:0];
            n_d = '0;
          end
        end else begin
          if (n_q >= COUNT_BITS'(d_q)) begin
            n_d = n_q - COUNT_BITS'(d_q);
            if (m_q == MonthMin) begin
              if (y_q == YearMin) begin
                m_d     = MonthMin;
                d_d     = DayMin;
                ovf_d   = 1'b1;
                state_d = ST_DONE;
              end else begin
                // December has the same length in every year
                y_d = y_q - 14'd1;
                m_d = Months;
                d_d = DecDays;
                r_d = (r_q == 14'd0) ? Mod25Top : (r_q - 14'd1);
              end
            end else begin
              m_d = m_q - 4'd1;
              d_d = month_len(leap, m_q - 4'd1);
            end
          end else begin
            d_d = d_q - n_q[4:0];
            n_d = '0;
          end
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q <= dir_d;
    y_q   <= y_d;
    m_q   <= m_d;
    d_q   <= d_d;
    n_q   <= n_d;
    ovf_q <= ovf_d;
    r_q   <= r_d;
    k_q   <= k_d;
    if (out_load) begin
      res_year_q  <= y_q;
      res_month_q <= m_q;
      res_day_q   <= d_q;
      res_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_year_o   = res_year_q;
  assign result_month_o  = res_month_q;
  assign result_day_o    = res_day_q;
  assign year_overflow_o = res_ovf_q;

  assign in_accept    = in_valid_i && in_ready_o;
  assign step_date_ok = (m_q >= MonthMin) && (m_q <= Months) &&
                        (d_q >= DayMin) && (d_q <= cur_len);
  assign res_clamped  = ((res_year_q == YearMax) && (res_month_q == Months) &&
                         (res_day_q == DecDays)) ||
                        ((res_year_q == YearMin) && (res_month_q == MonthMin) &&
                         (res_day_q == DayMin));

  `DOBD_ASSERT(a_step_date_ok, (state_q == ST_STEP) |-> step_date_ok, "date out of range in step")
  `DOBD_ASSERT_NEXT(a_accept_starts_mod, in_accept, state_q == ST_MOD, "mod pass not started")
  `DOBD_ASSERT(a_ovf_clamped, (out_valid_q && res_ovf_q) |-> res_clamped, "overflow not clamped")

endmodule

`default_nettype wire
